@@ design/hng_pkg.sv @@
// Shared types and constants of the height-map normal generator.
// No dependencies.
`timescale 1ns / 1ps
package hng_pkg;

   localparam int ROW_W   = 11;           // row counter, holds up to 1024
   localparam int MAX_ROWS = 1024;
   localparam int CFG_W   = 11;
   localparam int H_W     = 16;
   localparam int DIFF_W  = 17;
   localparam int SUM_W   = 34;
   localparam int RAD_W   = 62;
   localparam int ROOT_W  = 31;
   localparam int NUM_W   = 46;
   localparam int Q_W     = 16;
   localparam int B_VAL   = 512;          // 2.0 in Q8.8
   localparam int FRAC_SH = 29;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_RD0, ST_RD1, ST_RD2, ST_CAP, ST_SQA, ST_SQD,
      ST_ROOT, ST_ROOT_W, ST_DX, ST_DX_W, ST_DY, ST_DY_W, ST_DZ, ST_DZ_W, ST_OUT
   } state_type;

   typedef enum logic [1:0] {COMP_X, COMP_Y, COMP_Z} comp_type;

   typedef struct packed {
      logic     accept;
      logic     rd0;
      logic     rd1;
      logic     rd2;
      logic     cap;
      logic     sq_a;
      logic     sq_d;
      logic     sqrt_start;
      logic     div_start;
      comp_type div_sel;
      logic     load_out;
   } cmd_type;

   typedef struct packed {
      logic act;
      logic emit;
      logic sqrt_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ design/heightmap_normal_generator_top.sv @@
// Top level of the height-map normal generator.
// Depends on hng_pkg, hng_ctrl, hng_datapath.
`timescale 1ns / 1ps
// Height samples (command 0) arrive in raster order; the normal of point
// (c, r-1) leaves when sample (c, r) is taken, and after the last row one
// drain item (command 1) per column flushes that row, the final one flagged
// last_of_frame. Edge neighbours clamp. Components are Q1.15, rounded half up.
// An item that makes no result is dropped after the check (ignored) or after the
// line-memory reads (first row) before the next is taken; an item with a result
// runs through the bit-serial square root and then the shared bit-serial divider,
// run once per component, and waits for the result register to be free.
// The result register lets the next item start while a normal waits to be
// taken.
// Line memories hold no reset value; no clearing pass is needed.
module heightmap_normal_generator_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [15:0]        req_height_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_normal_x,
   output logic [14:0]        rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic [9:0]         rsp_out_col,
   output logic [9:0]         rsp_out_row,
   output logic               rsp_last_of_frame,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [10:0]        csr_wdata
);
   hng_pkg::cmd_type    cmd;
   hng_pkg::status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   hng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hng_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_command),
      .req_height_sample (req_height_sample),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_frame (rsp_last_of_frame)
   );
endmodule

@@ design/hng_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on hng_pkg.
`timescale 1ns / 1ps
module hng_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hng_pkg::RAD_W-1:0]  radicand,
   output logic [hng_pkg::ROOT_W-1:0] root,
   output logic                       done
);
   localparam int CW = $clog2(hng_pkg::ROOT_W);

   logic [hng_pkg::RAD_W-1:0]  val_ff, val_in;
   logic [hng_pkg::ROOT_W+1:0] rem_ff, rem_in;
   logic [hng_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [hng_pkg::ROOT_W+1:0] rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff[hng_pkg::ROOT_W-1:0], val_ff[hng_pkg::RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[hng_pkg::RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[hng_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[hng_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(hng_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

@@ design/hng_div.sv @@
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// Depends on hng_pkg.
`timescale 1ns / 1ps
module hng_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hng_pkg::NUM_W-1:0]  numer,
   input  logic [hng_pkg::ROOT_W-1:0] denom,
   output logic [hng_pkg::Q_W-1:0]    quot,
   output logic                       done
);
   localparam int CW = $clog2(hng_pkg::Q_W);

   logic [hng_pkg::ROOT_W-1:0] part_ff, part_in, den_ff, den_in;
   logic [hng_pkg::Q_W-1:0]    lo_ff, lo_in, q_ff, q_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [hng_pkg::ROOT_W:0]   p;

   always_comb begin
      p       = {part_ff, lo_ff[hng_pkg::Q_W-1]};
      part_in = part_ff;
      den_in  = den_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // quotient fits 16 bits, so the upper part is below the divisor
         part_in = hng_pkg::ROOT_W'(numer[hng_pkg::NUM_W-1:hng_pkg::Q_W]);
         lo_in   = numer[hng_pkg::Q_W-1:0];
         den_in  = denom;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         lo_in = {lo_ff[hng_pkg::Q_W-2:0], 1'b0};
         if (p >= {1'b0, den_ff}) begin
            part_in = hng_pkg::ROOT_W'(p - {1'b0, den_ff});
            q_in    = {q_ff[hng_pkg::Q_W-2:0], 1'b1};
         end else begin
            part_in = hng_pkg::ROOT_W'(p);
            q_in    = {q_ff[hng_pkg::Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(hng_pkg::Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      part_ff <= part_in;
      den_ff  <= den_in;
      lo_ff   <= lo_in;
      q_ff    <= q_in;
   end

   assign quot = q_ff;
   assign done = done_ff;
endmodule

@@ design/hng_ctrl.sv @@
// Sequencer of the normal generator: steps one item through reads,
// squaring, root and three divisions. Depends on hng_pkg.
`timescale 1ns / 1ps
module hng_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hng_pkg::status_type status,
   output hng_pkg::cmd_type    cmd
);
   hng_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hng_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = hng_pkg::COMP_X;
      req_ready   = 1'b0;
      case (state_ff)
         hng_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) state_in = hng_pkg::ST_CHECK;
         end
         hng_pkg::ST_CHECK: begin
            state_in = status.act ? hng_pkg::ST_RD0 : hng_pkg::ST_IDLE;
         end
         hng_pkg::ST_RD0: begin
            cmd.rd0  = 1'b1;
            state_in = hng_pkg::ST_RD1;
         end
         hng_pkg::ST_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = hng_pkg::ST_RD2;
         end
         hng_pkg::ST_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = hng_pkg::ST_CAP;
         end
         hng_pkg::ST_CAP: begin
            cmd.cap  = 1'b1;
            state_in = status.emit ? hng_pkg::ST_SQA : hng_pkg::ST_IDLE;
         end
         hng_pkg::ST_SQA: begin
            cmd.sq_a = 1'b1;
            state_in = hng_pkg::ST_SQD;
         end
         hng_pkg::ST_SQD: begin
            cmd.sq_d = 1'b1;
            state_in = hng_pkg::ST_ROOT;
         end
         hng_pkg::ST_ROOT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = hng_pkg::ST_ROOT_W;
         end
         hng_pkg::ST_ROOT_W: begin
            if (status.sqrt_done) state_in = hng_pkg::ST_DX;
         end
         hng_pkg::ST_DX: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = hng_pkg::COMP_X;
            state_in      = hng_pkg::ST_DX_W;
         end
         hng_pkg::ST_DX_W: begin
            if (status.div_done) state_in = hng_pkg::ST_DY;
         end
         hng_pkg::ST_DY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = hng_pkg::COMP_Y;
            state_in      = hng_pkg::ST_DY_W;
         end
         hng_pkg::ST_DY_W: begin
            if (status.div_done) state_in = hng_pkg::ST_DZ;
         end
         hng_pkg::ST_DZ: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = hng_pkg::COMP_Z;
            state_in      = hng_pkg::ST_DZ_W;
         end
         hng_pkg::ST_DZ_W: begin
            if (status.div_done) state_in = hng_pkg::ST_OUT;
         end
         hng_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = hng_pkg::ST_IDLE;
            end
         end
         default: state_in = hng_pkg::ST_IDLE;
      endcase
   end
endmodule

@@ design/hng_datapath.sv @@
// Datapath: config registers, raster counters, two line memories, squarer,
// root and divider units, result register. Depends on hng_pkg, hng_isqrt, hng_div.
`timescale 1ns / 1ps
module hng_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hng_pkg::cmd_type          cmd,
   output hng_pkg::status_type       status,
   input  logic                      req_command,
   input  logic [15:0]               req_height_sample,
   input  logic                      csr_valid,
   input  logic                      csr_index,
   input  logic [10:0]               csr_wdata,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [15:0]        rsp_normal_x,
   output logic [14:0]               rsp_normal_y,
   output logic signed [15:0]        rsp_normal_z,
   output logic [9:0]                rsp_out_col,
   output logic [9:0]                rsp_out_row,
   output logic                      rsp_last_of_frame
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = AW + 1;
   localparam int RW = hng_pkg::ROW_W;
   localparam int DW = hng_pkg::DIFF_W;

   // configuration
   logic [hng_pkg::CFG_W-1:0] map_width_ff, map_height_ff;
   logic [31:0] w_sel, h_sel;
   logic [WW-1:0] w;
   logic [RW-1:0] hh;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= hng_pkg::CFG_W'(256);
         map_height_ff <= hng_pkg::CFG_W'(256);
      end else if (csr_valid) begin
         case (csr_index)
            hng_pkg::REG_MAP_WIDTH:  map_width_ff  <= csr_wdata;
            hng_pkg::REG_MAP_HEIGHT: map_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_sel = 32'(map_width_ff);
      if (w_sel < 32'd2) w_sel = 32'd2;
      else if (w_sel > 32'(MAX_WIDTH)) w_sel = 32'(MAX_WIDTH);
      h_sel = 32'(map_height_ff);
      if (h_sel < 32'd2) h_sel = 32'd2;
      else if (h_sel > 32'(hng_pkg::MAX_ROWS)) h_sel = 32'(hng_pkg::MAX_ROWS);
   end
   assign w  = w_sel[WW-1:0];
   assign hh = h_sel[RW-1:0];

   // raster position and per-item latches
   logic [AW-1:0] in_col_ff, drain_col_ff, c_ff;
   logic [RW-1:0] in_row_ff;
   logic          drain_ff, act_ff, emit_ff, top_row_ff, last_ff;
   logic [9:0]    orow_ff;
   logic [15:0]   h_ff;
   logic          is_sample, acc_act;
   logic [AW-1:0] c_acc;
   logic [WW-1:0] c_acc_p1, c_p1;

   assign is_sample = (req_command == hng_pkg::CMD_SAMPLE);
   assign acc_act   = is_sample ? (in_row_ff < hh) : (in_row_ff >= hh);
   assign c_acc     = is_sample ? in_col_ff : drain_col_ff;
   assign c_acc_p1  = {1'b0, c_acc} + 1'b1;
   assign c_p1      = {1'b0, c_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else if (cmd.accept) begin
         act_ff <= acc_act;
      end
      if (cmd.accept) begin
         drain_ff   <= ~is_sample;
         emit_ff    <= ~is_sample || (in_row_ff != '0);
         c_ff       <= c_acc;
         h_ff       <= req_height_sample;
         orow_ff    <= 10'(in_row_ff - 1'b1);
         top_row_ff <= (in_row_ff == RW'(1));
         last_ff    <= ~is_sample && (c_acc_p1 >= w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         drain_col_ff <= '0;
      end else if (cmd.rd2) begin
         if (!drain_ff) begin
            if (c_p1 >= w) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 1'b1;
            end else begin
               in_col_ff <= c_p1[AW-1:0];
            end
         end else if (last_ff) begin
            in_col_ff    <= '0;
            in_row_ff    <= '0;
            drain_col_ff <= '0;
         end else begin
            drain_col_ff <= c_p1[AW-1:0];
         end
      end
   end

   // line memories: reads at c, then c+1 / c-1, then c-1; write in RD2
   logic [15:0] upper_mem [MAX_WIDTH];
   logic [15:0] middle_mem [MAX_WIDTH];
   logic [15:0] upper_q, middle_q;
   logic [AW-1:0] mid_addr, up_addr;
   logic [15:0] mid_ff, upc_ff, midp1_ff, upm1_ff;
   logic        mem_we;

   assign mem_we = cmd.rd2 && !drain_ff;

   always_comb begin
      mid_addr = c_ff;
      up_addr  = c_ff;
      if (cmd.rd1) begin
         mid_addr = c_ff + 1'b1;
         up_addr  = c_ff - 1'b1;
      end else if (cmd.rd2) begin
         mid_addr = c_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[c_ff]  <= mid_ff;
         middle_mem[c_ff] <= h_ff;
      end
      upper_q  <= upper_mem[up_addr];
      middle_q <= middle_mem[mid_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.rd1) begin
         mid_ff <= middle_q;
         upc_ff <= upper_q;
      end
      if (cmd.rd2) begin
         midp1_ff <= middle_q;
         upm1_ff  <= upper_q;
      end
   end

   // vector components
   logic [15:0] left, right, above, below;
   logic signed [DW-1:0] a_ff, d_ff;

   always_comb begin
      if (c_ff == '0)       left = mid_ff;
      else if (drain_ff)    left = middle_q;
      else                  left = upm1_ff;
      right = (c_p1 < w) ? midp1_ff : mid_ff;
      if (drain_ff)         above = upc_ff;
      else if (top_row_ff)  above = mid_ff;
      else                  above = upc_ff;
      below = drain_ff ? mid_ff : h_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         a_ff <= $signed({1'b0, left}) - $signed({1'b0, right});
         d_ff <= $signed({1'b0, above}) - $signed({1'b0, below});
      end
   end

   // sum of squares, one shared multiplier
   logic signed [DW-1:0]     mop;
   logic signed [2*DW-1:0]   prod;
   logic [hng_pkg::SUM_W-1:0] sum_ff;

   assign mop  = cmd.sq_a ? a_ff : d_ff;
   assign prod = mop * mop;

   always_ff @(posedge clock) begin
      if (cmd.sq_a) begin
         sum_ff <= prod[hng_pkg::SUM_W-1:0] + hng_pkg::SUM_W'(hng_pkg::B_VAL * hng_pkg::B_VAL);
      end else if (cmd.sq_d) begin
         sum_ff <= sum_ff + prod[hng_pkg::SUM_W-1:0];
      end
   end

   logic [hng_pkg::ROOT_W-1:0] root;
   logic sqrt_done;

   hng_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand ({sum_ff, 28'b0}),
      .root     (root),
      .done     (sqrt_done)
   );

   // division per component
   hng_pkg::comp_type    sel_ff;
   logic [DW-1:0]        v_abs;
   logic [15:0]          mag;
   logic [hng_pkg::NUM_W-1:0] numer;
   logic [hng_pkg::Q_W-1:0]   quot;
   logic                 div_done;
   logic [14:0]          sat;
   logic [14:0]          qx_ff, qy_ff, qz_ff;

   always_comb begin
      case (cmd.div_sel)
         hng_pkg::COMP_X: v_abs = a_ff[DW-1] ? DW'(-a_ff) : DW'(a_ff);
         hng_pkg::COMP_Z: v_abs = d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);
         default:         v_abs = DW'(hng_pkg::B_VAL);
      endcase
      mag   = v_abs[15:0];
      numer = (hng_pkg::NUM_W'(mag) << hng_pkg::FRAC_SH)
              + hng_pkg::NUM_W'(root[hng_pkg::ROOT_W-1:1]);
      sat   = (quot > 16'd32767) ? 15'd32767 : quot[14:0];
   end

   hng_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (root),
      .quot  (quot),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_start) sel_ff <= cmd.div_sel;
      if (div_done) begin
         case (sel_ff)
            hng_pkg::COMP_X: qx_ff <= sat;
            hng_pkg::COMP_Y: qy_ff <= sat;
            hng_pkg::COMP_Z: qz_ff <= sat;
            default: ;
         endcase
      end
   end

   // result register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_normal_x      <= a_ff[DW-1] ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
         rsp_normal_y      <= qy_ff;
         rsp_normal_z      <= d_ff[DW-1] ? -$signed({1'b0, qz_ff}) : $signed({1'b0, qz_ff});
         rsp_out_col       <= 10'(c_ff);
         rsp_out_row       <= orow_ff;
         rsp_last_of_frame <= last_ff;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   assign status.act       = act_ff;
   assign status.emit      = emit_ff;
   assign status.sqrt_done = sqrt_done;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // end of drain returns to the start of a frame
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      cmd.rd2 && drain_ff && last_ff |=> in_row_ff == '0 && drain_col_ff == '0)
      else $error("drain end did not reset the raster position");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= RW'(hng_pkg::MAX_ROWS))
      else $error("row counter past map limit");
   // vector length is at least 2.0, so the root has its upper bits set
   a_root_min: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> root[hng_pkg::ROOT_W-1:23] != '0)
      else $error("root below vector minimum");
   a_quot_max: assert property (@(posedge clock) disable iff (reset)
      div_done |-> quot <= 16'd32768)
      else $error("component quotient above unity");
endmodule
